[sv/obso_pkg.sv]
// ----------------------------------------------------------------------------
// obso_pkg
// Shared widths, register codes and the stage-to-stage record of the oriented
// box against segment overlap pipeline.
// ----------------------------------------------------------------------------
package obso_pkg;

  // Field widths
  localparam int COORD_W    = 24;  // Q15.8 coordinates
  localparam int HEAD_W     = 16;  // Q1.14 heading terms
  localparam int CFG_W      = 16;  // configuration data
  localparam int CFG_IDX_W  = 2;   // configuration register index

  // Fixed-point shifts
  localparam int FRAC_SHIFT = 14;  // heading fraction bits
  localparam int DIM_SHIFT  = 28;  // box size scale against the rotated frame

  // Datapath widths
  localparam int SUM_W   = COORD_W + 2;        // a + b - 2*pos
  localparam int VEC_W   = COORD_W + 1;        // b - a
  localparam int D_W     = COORD_W + 18;       // doubled midpoint in 2^-22 m
  localparam int PROD_W  = HEAD_W + D_W;       // heading term times D
  localparam int M_W     = PROD_W + 1;         // rotated midpoint
  localparam int X_W     = VEC_W + D_W;        // v times D
  localparam int CR_W    = X_W + 1;            // cross product
  localparam int VP_W    = HEAD_W + VEC_W;     // heading term times v
  localparam int AV_W    = VP_W + 1;           // rotated direction magnitude
  localparam int NORM_W  = 2 * HEAD_W;         // c*c + s*s
  localparam int BND_W   = AV_W + FRAC_SHIFT + 1;
  localparam int RHS_W   = AV_W + CFG_W + 1;
  localparam int CR_LO_W = CR_W / 2;
  localparam int CR_HI_W = CR_W - CR_LO_W;
  localparam int PLO_W   = CR_LO_W + NORM_W;
  localparam int PHI_W   = CR_HI_W + NORM_W;
  localparam int LHS_W   = CR_W + NORM_W + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAR_LENGTH    = CFG_IDX_W'(0),
    REG_CAR_WIDTH     = CFG_IDX_W'(1),
    REG_CENTER_OFFSET = CFG_IDX_W'(2)
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] CAR_LENGTH_RST    = CFG_W'(1280);
  localparam logic [CFG_W-1:0] CAR_WIDTH_RST     = CFG_W'(512);
  localparam logic [CFG_W-1:0] CENTER_OFFSET_RST = CFG_W'(384);

  // Products handed from the frame transform to the separation tests
  typedef struct packed {
    logic signed [PROD_W-1:0] cdx;
    logic signed [PROD_W-1:0] sdy;
    logic signed [PROD_W-1:0] sdx;
    logic signed [PROD_W-1:0] cdy;
    logic signed [X_W-1:0]    vxdy;
    logic signed [X_W-1:0]    vydx;
    logic [AV_W-1:0]          avx;
    logic [AV_W-1:0]          avy;
    logic [NORM_W-1:0]        norm;
  } obso_frame_t;

endpackage

[sv/obso_frame.sv]
// ----------------------------------------------------------------------------
// obso_frame
// Three pipeline stages that move the segment into the box frame: midpoint
// and direction, heading rotation terms, and the products for the tests.
// ----------------------------------------------------------------------------
module obso_frame (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [obso_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [obso_pkg::COORD_W-1:0]  pos_y_i,
  input  logic signed [obso_pkg::HEAD_W-1:0]   heading_cos_i,
  input  logic signed [obso_pkg::HEAD_W-1:0]   heading_sin_i,
  input  logic signed [obso_pkg::COORD_W-1:0]  seg_ax_i,
  input  logic signed [obso_pkg::COORD_W-1:0]  seg_ay_i,
  input  logic signed [obso_pkg::COORD_W-1:0]  seg_bx_i,
  input  logic signed [obso_pkg::COORD_W-1:0]  seg_by_i,
  input  logic signed [obso_pkg::CFG_W-1:0]    center_offset_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output obso_pkg::obso_frame_t                frame_o
);

  logic [2:0] vld_q;
  logic       en_s1, en_s2, en_s3;

  // Stage 1 registers
  logic signed [obso_pkg::SUM_W-1:0]  s1_sumx_q, s1_sumy_q, s1_sumx_d, s1_sumy_d;
  logic signed [obso_pkg::VEC_W-1:0]  s1_vx_q, s1_vy_q, s1_vx_d, s1_vy_d;
  logic signed [obso_pkg::HEAD_W-1:0] s1_c_q, s1_s_q;
  logic signed [obso_pkg::NORM_W-1:0] s1_coff_q, s1_soff_q, s1_coff_d, s1_soff_d;
  logic signed [obso_pkg::NORM_W-1:0] s1_cc_q, s1_ss_q, s1_cc_d, s1_ss_d;

  // Stage 2 registers
  logic signed [obso_pkg::D_W-1:0]    s2_dx_q, s2_dy_q, s2_dx_d, s2_dy_d;
  logic signed [obso_pkg::VEC_W-1:0]  s2_vx_q, s2_vy_q;
  logic signed [obso_pkg::HEAD_W-1:0] s2_c_q, s2_s_q;
  logic signed [obso_pkg::VP_W-1:0]   s2_cvx_q, s2_svy_q, s2_svx_q, s2_cvy_q;
  logic signed [obso_pkg::VP_W-1:0]   s2_cvx_d, s2_svy_d, s2_svx_d, s2_cvy_d;
  logic [obso_pkg::NORM_W-1:0]        s2_norm_q, s2_norm_d;

  // Stage 3 registers
  obso_pkg::obso_frame_t              s3_frame_q, s3_frame_d;
  logic signed [obso_pkg::AV_W-1:0]   vxr, vyr;

  // Advance a stage when it is empty or the next one moves
  assign en_s3   = !vld_q[2] || ready_i;
  assign en_s2   = !vld_q[1] || en_s3;
  assign en_s1   = !vld_q[0] || en_s2;
  assign ready_o = en_s1;
  assign valid_o = vld_q[2];
  assign frame_o = s3_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_s1) vld_q[0] <= valid_i;
      if (en_s2) vld_q[1] <= vld_q[0];
      if (en_s3) vld_q[2] <= vld_q[1];
    end
  end

  // Stage 1: doubled midpoint offset, direction, heading products
  always_comb begin
    s1_sumx_d = obso_pkg::SUM_W'(seg_ax_i) + obso_pkg::SUM_W'(seg_bx_i)
              - (obso_pkg::SUM_W'(pos_x_i) <<< 1);
    s1_sumy_d = obso_pkg::SUM_W'(seg_ay_i) + obso_pkg::SUM_W'(seg_by_i)
              - (obso_pkg::SUM_W'(pos_y_i) <<< 1);
    s1_vx_d   = obso_pkg::VEC_W'(seg_bx_i) - obso_pkg::VEC_W'(seg_ax_i);
    s1_vy_d   = obso_pkg::VEC_W'(seg_by_i) - obso_pkg::VEC_W'(seg_ay_i);
    s1_coff_d = obso_pkg::NORM_W'(heading_cos_i) * obso_pkg::NORM_W'(center_offset_i);
    s1_soff_d = obso_pkg::NORM_W'(heading_sin_i) * obso_pkg::NORM_W'(center_offset_i);
    s1_cc_d   = obso_pkg::NORM_W'(heading_cos_i) * obso_pkg::NORM_W'(heading_cos_i);
    s1_ss_d   = obso_pkg::NORM_W'(heading_sin_i) * obso_pkg::NORM_W'(heading_sin_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      s1_sumx_q <= s1_sumx_d;
      s1_sumy_q <= s1_sumy_d;
      s1_vx_q   <= s1_vx_d;
      s1_vy_q   <= s1_vy_d;
      s1_c_q    <= heading_cos_i;
      s1_s_q    <= heading_sin_i;
      s1_coff_q <= s1_coff_d;
      s1_soff_q <= s1_soff_d;
      s1_cc_q   <= s1_cc_d;
      s1_ss_q   <= s1_ss_d;
    end
  end

  // Stage 2: midpoint relative to box centre, rotated direction terms
  always_comb begin
    s2_dx_d   = (obso_pkg::D_W'(s1_sumx_q) <<< obso_pkg::FRAC_SHIFT)
              - (obso_pkg::D_W'(s1_coff_q) <<< 1);
    s2_dy_d   = (obso_pkg::D_W'(s1_sumy_q) <<< obso_pkg::FRAC_SHIFT)
              - (obso_pkg::D_W'(s1_soff_q) <<< 1);
    s2_cvx_d  = obso_pkg::VP_W'(s1_c_q) * obso_pkg::VP_W'(s1_vx_q);
    s2_svy_d  = obso_pkg::VP_W'(s1_s_q) * obso_pkg::VP_W'(s1_vy_q);
    s2_svx_d  = obso_pkg::VP_W'(s1_s_q) * obso_pkg::VP_W'(s1_vx_q);
    s2_cvy_d  = obso_pkg::VP_W'(s1_c_q) * obso_pkg::VP_W'(s1_vy_q);
    s2_norm_d = $unsigned(s1_cc_q) + $unsigned(s1_ss_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_s2) begin
      s2_dx_q   <= s2_dx_d;
      s2_dy_q   <= s2_dy_d;
      s2_vx_q   <= s1_vx_q;
      s2_vy_q   <= s1_vy_q;
      s2_c_q    <= s1_c_q;
      s2_s_q    <= s1_s_q;
      s2_cvx_q  <= s2_cvx_d;
      s2_svy_q  <= s2_svy_d;
      s2_svx_q  <= s2_svx_d;
      s2_cvy_q  <= s2_cvy_d;
      s2_norm_q <= s2_norm_d;
    end
  end

  // Stage 3: rotate the midpoint, form cross terms, take direction magnitudes
  always_comb begin
    vxr = obso_pkg::AV_W'(s2_cvx_q) + obso_pkg::AV_W'(s2_svy_q);
    vyr = obso_pkg::AV_W'(s2_cvy_q) - obso_pkg::AV_W'(s2_svx_q);
    s3_frame_d.cdx  = obso_pkg::PROD_W'(s2_c_q) * obso_pkg::PROD_W'(s2_dx_q);
    s3_frame_d.sdy  = obso_pkg::PROD_W'(s2_s_q) * obso_pkg::PROD_W'(s2_dy_q);
    s3_frame_d.sdx  = obso_pkg::PROD_W'(s2_s_q) * obso_pkg::PROD_W'(s2_dx_q);
    s3_frame_d.cdy  = obso_pkg::PROD_W'(s2_c_q) * obso_pkg::PROD_W'(s2_dy_q);
    s3_frame_d.vxdy = obso_pkg::X_W'(s2_vx_q) * obso_pkg::X_W'(s2_dy_q);
    s3_frame_d.vydx = obso_pkg::X_W'(s2_vy_q) * obso_pkg::X_W'(s2_dx_q);
    s3_frame_d.avx  = vxr[obso_pkg::AV_W-1] ? $unsigned(-vxr) : $unsigned(vxr);
    s3_frame_d.avy  = vyr[obso_pkg::AV_W-1] ? $unsigned(-vyr) : $unsigned(vyr);
    s3_frame_d.norm = s2_norm_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_s3) begin
      s3_frame_q <= s3_frame_d;
    end
  end

endmodule

[sv/obso_sat.sv]
// ----------------------------------------------------------------------------
// obso_sat
// Three pipeline stages of separating-axis tests: box x axis, box y axis and
// segment normal. The last stage is the output register.
// ----------------------------------------------------------------------------
module obso_sat (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  obso_pkg::obso_frame_t        frame_i,
  input  logic [obso_pkg::CFG_W-1:0]   car_length_i,
  input  logic [obso_pkg::CFG_W-1:0]   car_width_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic                         overlap_o
);

  logic [2:0] vld_q;
  logic       en_s4, en_s5, en_s6;

  // Stage 4 registers
  logic signed [obso_pkg::M_W-1:0]  mx, my;
  logic signed [obso_pkg::CR_W-1:0] cr;
  logic [obso_pkg::M_W-1:0]         s4_amx_q, s4_amy_q, s4_amx_d, s4_amy_d;
  logic [obso_pkg::CR_W-1:0]        s4_acr_q, s4_acr_d;
  logic [obso_pkg::BND_W-1:0]       s4_bndx_q, s4_bndy_q, s4_bndx_d, s4_bndy_d;
  logic [obso_pkg::RHS_W-1:0]       s4_avxw_q, s4_avyl_q, s4_avxw_d, s4_avyl_d;
  logic [obso_pkg::NORM_W-1:0]      s4_norm_q;

  // Stage 5 registers
  logic                             s5_sepxy_q, s5_sepxy_d;
  logic [obso_pkg::PLO_W-1:0]       s5_plo_q, s5_plo_d;
  logic [obso_pkg::PHI_W-1:0]       s5_phi_q, s5_phi_d;
  logic [obso_pkg::RHS_W-1:0]       s5_rhs_q, s5_rhs_d;

  // Stage 6 registers
  logic [obso_pkg::LHS_W-1:0]       lhs;
  logic                             overlap_q, overlap_d;

  // Advance a stage when it is empty or the next one moves
  assign en_s6     = !vld_q[2] || !stall_i;
  assign en_s5     = !vld_q[1] || en_s6;
  assign en_s4     = !vld_q[0] || en_s5;
  assign ready_o   = en_s4;
  assign valid_o   = vld_q[2];
  assign overlap_o = overlap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_s4) vld_q[0] <= valid_i;
      if (en_s5) vld_q[1] <= vld_q[0];
      if (en_s6) vld_q[2] <= vld_q[1];
    end
  end

  // Stage 4: sum rotated terms, take magnitudes, build the axis bounds
  always_comb begin
    mx = obso_pkg::M_W'(frame_i.cdx) + obso_pkg::M_W'(frame_i.sdy);
    my = obso_pkg::M_W'(frame_i.cdy) - obso_pkg::M_W'(frame_i.sdx);
    cr = obso_pkg::CR_W'(frame_i.vxdy) - obso_pkg::CR_W'(frame_i.vydx);
    s4_amx_d  = mx[obso_pkg::M_W-1]  ? $unsigned(-mx) : $unsigned(mx);
    s4_amy_d  = my[obso_pkg::M_W-1]  ? $unsigned(-my) : $unsigned(my);
    s4_acr_d  = cr[obso_pkg::CR_W-1] ? $unsigned(-cr) : $unsigned(cr);
    s4_bndx_d = (obso_pkg::BND_W'(frame_i.avx) << obso_pkg::FRAC_SHIFT)
              + (obso_pkg::BND_W'(car_length_i) << obso_pkg::DIM_SHIFT);
    s4_bndy_d = (obso_pkg::BND_W'(frame_i.avy) << obso_pkg::FRAC_SHIFT)
              + (obso_pkg::BND_W'(car_width_i) << obso_pkg::DIM_SHIFT);
    s4_avxw_d = obso_pkg::RHS_W'(frame_i.avx) * obso_pkg::RHS_W'(car_width_i);
    s4_avyl_d = obso_pkg::RHS_W'(frame_i.avy) * obso_pkg::RHS_W'(car_length_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_s4) begin
      s4_amx_q  <= s4_amx_d;
      s4_amy_q  <= s4_amy_d;
      s4_acr_q  <= s4_acr_d;
      s4_bndx_q <= s4_bndx_d;
      s4_bndy_q <= s4_bndy_d;
      s4_avxw_q <= s4_avxw_d;
      s4_avyl_q <= s4_avyl_d;
      s4_norm_q <= frame_i.norm;
    end
  end

  // Stage 5: box axis tests, split cross-term product, normal bound
  always_comb begin
    s5_sepxy_d = (s4_amx_q > obso_pkg::M_W'(s4_bndx_q))
              || (s4_amy_q > obso_pkg::M_W'(s4_bndy_q));
    s5_plo_d   = obso_pkg::PLO_W'(s4_acr_q[obso_pkg::CR_LO_W-1:0])
               * obso_pkg::PLO_W'(s4_norm_q);
    s5_phi_d   = obso_pkg::PHI_W'(s4_acr_q[obso_pkg::CR_W-1:obso_pkg::CR_LO_W])
               * obso_pkg::PHI_W'(s4_norm_q);
    s5_rhs_d   = s4_avxw_q + s4_avyl_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_s5) begin
      s5_sepxy_q <= s5_sepxy_d;
      s5_plo_q   <= s5_plo_d;
      s5_phi_q   <= s5_phi_d;
      s5_rhs_q   <= s5_rhs_d;
    end
  end

  // Stage 6: join the partial products, test the normal, combine
  always_comb begin
    lhs = obso_pkg::LHS_W'(s5_plo_q)
        + (obso_pkg::LHS_W'(s5_phi_q) << obso_pkg::CR_LO_W);
    overlap_d = !(s5_sepxy_q
               || (lhs > (obso_pkg::LHS_W'(s5_rhs_q) << obso_pkg::DIM_SHIFT)));
  end

  always_ff @(posedge clk_i) begin
    if (en_s6) begin
      overlap_q <= overlap_d;
    end
  end

endmodule

[sv/oriented_box_segment_overlap.sv]
// ----------------------------------------------------------------------------
// oriented_box_segment_overlap
// Separating-axis overlap test of a vehicle footprint box against one
// obstacle segment, fully pipelined.
//
//   channel   handshake                     payload
//   --------  ----------------------------  ---------------------------------
//   input     in_valid_i / in_stall_o       pose, heading, segment endpoints
//   result    out_valid_o / out_stall_i     overlap_o
//   config    cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// One item per cycle while out_stall_i is low. An accepted item passes the six
// register stages (three frame transform, three tests) in order, and
// out_valid_o rises when it reaches the last one.
// Reset clears all stage valid bits and loads the register reset values.
// A stalled result holds in the output stage; earlier stages keep filling
// bubbles, and the input stalls only when every stage holds an item.
// ----------------------------------------------------------------------------
module oriented_box_segment_overlap (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [obso_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [obso_pkg::CFG_W-1:0]              cfg_data_i,
  // Input items
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [obso_pkg::COORD_W-1:0]     pos_x_i,
  input  logic signed [obso_pkg::COORD_W-1:0]     pos_y_i,
  input  logic signed [obso_pkg::HEAD_W-1:0]      heading_cos_i,
  input  logic signed [obso_pkg::HEAD_W-1:0]      heading_sin_i,
  input  logic signed [obso_pkg::COORD_W-1:0]     seg_ax_i,
  input  logic signed [obso_pkg::COORD_W-1:0]     seg_ay_i,
  input  logic signed [obso_pkg::COORD_W-1:0]     seg_bx_i,
  input  logic signed [obso_pkg::COORD_W-1:0]     seg_by_i,
  // Result items
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    overlap_o
);

  logic [obso_pkg::CFG_W-1:0]        car_length_q;
  logic [obso_pkg::CFG_W-1:0]        car_width_q;
  logic signed [obso_pkg::CFG_W-1:0] center_offset_q;

  logic                              frame_ready;
  logic                              frame_valid;
  logic                              sat_ready;
  obso_pkg::obso_frame_t             frame;

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_length_q    <= obso_pkg::CAR_LENGTH_RST;
      car_width_q     <= obso_pkg::CAR_WIDTH_RST;
      center_offset_q <= obso_pkg::CENTER_OFFSET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (obso_pkg::cfg_reg_e'(cfg_index_i))
        obso_pkg::REG_CAR_LENGTH:    car_length_q    <= cfg_data_i;
        obso_pkg::REG_CAR_WIDTH:     car_width_q     <= cfg_data_i;
        obso_pkg::REG_CENTER_OFFSET: center_offset_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign in_stall_o = !frame_ready;

  // Transform the segment into the box frame
  obso_frame u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .ready_o         (frame_ready),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .heading_cos_i   (heading_cos_i),
    .heading_sin_i   (heading_sin_i),
    .seg_ax_i        (seg_ax_i),
    .seg_ay_i        (seg_ay_i),
    .seg_bx_i        (seg_bx_i),
    .seg_by_i        (seg_by_i),
    .center_offset_i (center_offset_q),
    .valid_o         (frame_valid),
    .ready_i         (sat_ready),
    .frame_o         (frame)
  );

  // Run the separating-axis tests
  obso_sat u_sat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (frame_valid),
    .ready_o      (sat_ready),
    .frame_i      (frame),
    .car_length_i (car_length_q),
    .car_width_i  (car_width_q),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .overlap_o    (overlap_o)
  );

endmodule

[sv/obso_checker.sv]
// ----------------------------------------------------------------------------
// obso_checker
// Port-level checks of the overlap pipeline: stall behavior, drain, latency
// and the zero-heading result.
// ----------------------------------------------------------------------------
module obso_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic signed [obso_pkg::HEAD_W-1:0]  heading_cos_i,
  input logic signed [obso_pkg::HEAD_W-1:0]  heading_sin_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                overlap_o
);

  logic in_acc;
  logic zero_heading;

  assign in_acc       = in_valid_i && !in_stall_o;
  assign zero_heading = (heading_cos_i == '0) && (heading_sin_i == '0);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(overlap_o))
    else $error("stalled result changed");

  // Stall the input only when the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // Drain when no input arrives and the output is not stalled
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i)
    ##1 (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i)
    ##1 (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i)
    |=> !out_valid_o)
    else $error("pipeline did not drain");

  // Zero heading always overlaps, once the item has passed every stage unstalled
  a_zero_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && zero_heading) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o && overlap_o)
    else $error("zero heading item did not report overlap");

endmodule

bind oriented_box_segment_overlap obso_checker u_obso_checker (.*);
